// ===== rtl/rch2d_pkg.sv =====
// Package for the 2D ray closest-hit block: field widths, register addresses and the sequencer state type.
// Used by rtl/ray_closest_hit_2d_top.sv and test/testbench.sv; depends on nothing else.
package rch2d_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned DIR_W  = 16;
  localparam int unsigned DIST_W = 23;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned ID_W   = 10;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned IN_DW  = 64;
  localparam int unsigned OUT_DW = 120;

  localparam logic [CFG_AW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DIR_X    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIR_Y    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_DIST = 3'd4;
  localparam logic [CFG_AW-1:0] REG_HIT_THR  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_THR, ST_TX, ST_TY, ST_PROJ, ST_CX, ST_CY, ST_SQX, ST_SQY,
    ST_UPD, ST_FIN, ST_SQRT, ST_DIVX, ST_DIVY, ST_OUT
  } rch2d_state_t;

endpackage

// ===== rtl/ray_closest_hit_2d_top.sv =====
// Nearest collider hit along one 2D ray, built round one shared 25 x 25 bit multiplier.
// Depends on rtl/rch2d_pkg.sv.
//
// Each collider transfer runs the steps of the multiply sequencer in turn (threshold
// square, dot product, closest point, squared offset, compare); a collider whose projection
// fails leaves after the projection test, and one beyond the collider limit of the query
// after the threshold square. The transfer marked last then adds a finishing pass: a direct
// move to the output when there is no hit or a zero offset, otherwise a bit-serial square root
// and two restoring divisions for the unit normal. The block takes no input while an item
// is being worked on or while a result waits on the output.
module ray_closest_hit_2d_top #(
  parameter int unsigned MAX_COLLIDERS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pos_x[23:0], pos_y[47:24], collider_id[57:48], zero fill
  input  logic [rch2d_pkg::IN_DW-1:0]   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // hit_id[9:0], point_x[33:10], point_y[57:34], hit_distance[80:58],
  // normal_x[96:81], normal_y[112:97], zero fill
  output logic [rch2d_pkg::OUT_DW-1:0]  out_tdata,
  // hit_found
  output logic                          out_tuser,
  input  logic                          cfg_we,
  input  logic [rch2d_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [rch2d_pkg::POS_W-1:0]   cfg_wdata
);
  import rch2d_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_COLLIDERS + 1);

  // configuration
  logic signed [23:0] origin_x_r, origin_y_r;
  logic signed [15:0] dir_x_r, dir_y_r;
  logic [22:0]        max_dist_r;
  logic [THR_W-1:0]   thr_r;

  // query state
  rch2d_state_t state_r, state_nxt;
  logic               open_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               found_r;
  logic [22:0]        best_dist_r;
  logic [9:0]         best_id_r;
  logic signed [23:0] best_px_r, best_py_r;
  logic signed [16:0] best_ox_r, best_oy_r;
  logic [31:0]        best_m_r;

  // item working registers
  logic signed [23:0] px_r, py_r;
  logic [9:0]         id_r;
  logic               last_r;
  logic signed [24:0] tx_r, ty_r;
  logic [31:0]        thr_sq_r;
  logic signed [41:0] acc_r;
  logic [22:0]        proj_r;
  logic signed [26:0] cx_r, cy_r;
  logic signed [27:0] ox_r, oy_r;

  // finishing pass
  logic [59:0]        sq_n_r, sq_q_r;
  logic [58:0]        sq_b_r;
  logic [30:0]        len_r;
  logic [44:0]        rem_r, div_d_r;
  logic [14:0]        quo_r;
  logic [4:0]         step_r;
  logic signed [15:0] nx_r, ny_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [OUT_DW-1:0]  out_data_r;

  // shared multiplier
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_THR: begin
        mul_a = $signed({9'd0, thr_r});
        mul_b = $signed({9'd0, thr_r});
      end
      ST_TX: begin
        mul_a = tx_r;
        mul_b = 25'(dir_x_r);
      end
      ST_TY: begin
        mul_a = ty_r;
        mul_b = 25'(dir_y_r);
      end
      ST_CX: begin
        mul_a = 25'(dir_x_r);
        mul_b = $signed({2'd0, proj_r});
      end
      ST_CY: begin
        mul_a = 25'(dir_y_r);
        mul_b = $signed({2'd0, proj_r});
      end
      ST_SQX: begin
        mul_a = ox_r[24:0];
        mul_b = ox_r[24:0];
      end
      ST_SQY: begin
        mul_a = oy_r[24:0];
        mul_b = oy_r[24:0];
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // projection test on the registered dot product
  logic signed [27:0] proj_full;
  logic               proj_ok;
  assign proj_full = acc_r[41:14];
  assign proj_ok   = !proj_full[27] && (proj_full != '0) && (proj_full[27:23] == '0) &&
                     (proj_full[22:0] < best_dist_r);

  logic signed [26:0] pt_new;
  assign pt_new = 27'(origin_x_r) + 27'($signed(mul_p[39:14]));
  logic signed [26:0] pt_new_y;
  assign pt_new_y = 27'(origin_y_r) + 27'($signed(mul_p[39:14]));

  // offsets that do not fit in seventeen signed bits cannot be inside the threshold
  logic ox_small, oy_small;
  assign ox_small = (ox_r[27:16] == '0) || (ox_r[27:16] == '1);
  assign oy_small = (oy_r[27:16] == '0) || (oy_r[27:16] == '1);

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v[26:23] == 4'b0000 || v[26:23] == 4'b1111) begin
      return v[23:0];
    end else if (v[26]) begin
      return 24'sh800000;
    end else begin
      return 24'sh7fffff;
    end
  endfunction

  // square root step
  logic [60:0] sq_try;
  assign sq_try = {1'b0, sq_q_r} + {2'b0, sq_b_r};

  // division step
  logic [44:0] rem_sub;
  logic        div_ge;
  logic [14:0] quo_nxt;
  logic [14:0] quo_cl;
  assign div_ge  = rem_r >= div_d_r;
  assign rem_sub = rem_r - div_d_r;
  assign quo_nxt = {quo_r[13:0], div_ge};
  assign quo_cl  = (quo_nxt > 15'd16384) ? 15'd16384 : quo_nxt;

  logic [15:0] abs_oy;
  assign abs_oy = best_oy_r[16] ? 16'(-best_oy_r) : best_oy_r[15:0];
  logic [15:0] abs_ox;
  assign abs_ox = best_ox_r[16] ? 16'(-best_ox_r) : best_ox_r[15:0];

  logic in_fire;
  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = ST_THR;
      end
      ST_THR: begin
        if (cnt_r < CNT_W'(MAX_COLLIDERS)) begin
          state_nxt = ST_TX;
        end else begin
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_TX:  state_nxt = ST_TY;
      ST_TY:  state_nxt = ST_PROJ;
      ST_PROJ: begin
        if (proj_ok) begin
          state_nxt = ST_CX;
        end else begin
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_CX:  state_nxt = ST_CY;
      ST_CY:  state_nxt = ST_SQX;
      ST_SQX: state_nxt = ST_SQY;
      ST_SQY: state_nxt = ST_UPD;
      ST_UPD: state_nxt = last_r ? ST_FIN : ST_IDLE;
      ST_FIN: state_nxt = (found_r && best_m_r != '0) ? ST_SQRT : ST_OUT;
      ST_SQRT: if (step_r == '0) begin
        state_nxt = ST_DIVX;
      end
      ST_DIVX: if (step_r == '0) begin
        state_nxt = ST_DIVY;
      end
      ST_DIVY: if (step_r == '0) begin
        state_nxt = ST_OUT;
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      dir_x_r    <= 16'sd16384;
      dir_y_r    <= '0;
      max_dist_r <= 23'h7fffff;
      thr_r      <= 16'd512;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        REG_DIR_X:    dir_x_r    <= cfg_wdata[15:0];
        REG_DIR_Y:    dir_y_r    <= cfg_wdata[15:0];
        REG_MAX_DIST: max_dist_r <= cfg_wdata[22:0];
        REG_HIT_THR:  thr_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // query control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (in_fire && !open_r) begin
        open_r  <= 1'b1;
        cnt_r   <= '0;
        found_r <= 1'b0;
      end
      if (state_r == ST_TX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_UPD && ox_small && oy_small && acc_r < 42'(thr_sq_r)) begin
        found_r <= 1'b1;
      end
      if (state_r == ST_OUT) begin
        open_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r   <= in_tdata[23:0];
      py_r   <= in_tdata[47:24];
      id_r   <= in_tdata[57:48];
      last_r <= in_tlast;
      tx_r   <= 25'($signed(in_tdata[23:0])) - 25'(origin_x_r);
      ty_r   <= 25'($signed(in_tdata[47:24])) - 25'(origin_y_r);
      if (!open_r) begin
        best_dist_r <= max_dist_r;
        best_id_r   <= '0;
        best_px_r   <= '0;
        best_py_r   <= '0;
        best_ox_r   <= '0;
        best_oy_r   <= '0;
        best_m_r    <= '0;
      end
    end
    unique case (state_r)
      ST_THR:  thr_sq_r <= mul_p[31:0];
      ST_TX:   acc_r <= mul_p[41:0];
      ST_TY:   acc_r <= acc_r + mul_p[41:0];
      ST_PROJ: proj_r <= proj_full[22:0];
      ST_CX:   cx_r <= pt_new;
      ST_CY: begin
        cy_r <= pt_new_y;
        ox_r <= 28'(cx_r) - 28'(px_r);
      end
      ST_SQX: begin
        acc_r <= mul_p[41:0];
        oy_r  <= 28'(cy_r) - 28'(py_r);
      end
      ST_SQY:  acc_r <= acc_r + mul_p[41:0];
      ST_UPD: begin
        if (ox_small && oy_small && acc_r < 42'(thr_sq_r)) begin
          best_dist_r <= proj_r;
          best_id_r   <= id_r;
          best_px_r   <= sat24(cx_r);
          best_py_r   <= sat24(cy_r);
          best_ox_r   <= ox_r[16:0];
          best_oy_r   <= oy_r[16:0];
          best_m_r    <= acc_r[31:0];
        end
      end
      ST_FIN: begin
        nx_r   <= '0;
        ny_r   <= '0;
        sq_n_r <= {best_m_r, 28'd0};
        sq_q_r <= '0;
        sq_b_r <= {1'b1, 58'd0};
        step_r <= 5'd29;
      end
      ST_SQRT: begin
        if (sq_try <= {1'b0, sq_n_r}) begin
          sq_n_r <= sq_n_r - sq_try[59:0];
          sq_q_r <= (sq_q_r >> 1) + {1'b0, sq_b_r};
        end else begin
          sq_q_r <= sq_q_r >> 1;
        end
        sq_b_r <= sq_b_r >> 2;
        if (step_r == '0) begin
          // the last step leaves the root in the quotient register
          len_r   <= (sq_try <= {1'b0, sq_n_r}) ? 31'((sq_q_r >> 1) + {1'b0, sq_b_r})
                                                 : 31'(sq_q_r >> 1);
          rem_r   <= ({13'd0, abs_ox, 16'd0} << 12) +
                     45'(((sq_try <= {1'b0, sq_n_r}) ? ((sq_q_r >> 1) + {1'b0, sq_b_r})
                                                     : (sq_q_r >> 1)) >> 1);
          div_d_r <= 45'(((sq_try <= {1'b0, sq_n_r}) ? ((sq_q_r >> 1) + {1'b0, sq_b_r})
                                                     : (sq_q_r >> 1))) << 14;
          quo_r   <= '0;
          step_r  <= 5'd14;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
      ST_DIVX: begin
        if (step_r == '0) begin
          nx_r    <= best_ox_r[16] ? -$signed({1'b0, quo_cl}) : $signed({1'b0, quo_cl});
          rem_r   <= {1'b0, abs_oy, 28'd0} + 45'(len_r >> 1);
          div_d_r <= 45'(len_r) << 14;
          quo_r   <= '0;
          step_r  <= 5'd14;
        end else begin
          rem_r   <= div_ge ? rem_sub : rem_r;
          quo_r   <= quo_nxt;
          div_d_r <= div_d_r >> 1;
          step_r  <= step_r - 1'b1;
        end
      end
      ST_DIVY: begin
        if (step_r == '0) begin
          ny_r <= best_oy_r[16] ? -$signed({1'b0, quo_cl}) : $signed({1'b0, quo_cl});
        end else begin
          rem_r   <= div_ge ? rem_sub : rem_r;
          quo_r   <= quo_nxt;
          div_d_r <= div_d_r >> 1;
          step_r  <= step_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      out_found_r <= found_r;
      if (found_r) begin
        out_data_r <= {7'd0, ny_r, nx_r, best_dist_r, best_py_r, best_px_r, best_id_r};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after an input transfer");

  a_root_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> found_r && best_m_r != '0)
    else $error("square root started without a hit offset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_COLLIDERS))
    else $error("item count passed the collider limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> !out_valid_r)
    else $error("result loaded over a pending transfer");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for ray_closest_hit_2d_top: streams collider queries and compares
// every result transfer with a built-in predictor of the nearest-hit search.
// Depends on rtl/rch2d_pkg.sv and rtl/ray_closest_hit_2d_top.sv.
`timescale 1ns / 1ps

module testbench;
  import rch2d_pkg::*;

  localparam logic [CFG_AW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_7 = 3'd7;
  localparam int MAX_QUERY = 1024;
  localparam int SETTLE = 120;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [ID_W-1:0] id;
    bit last;
  } collider_t;

  typedef struct packed {
    bit found;
    logic [ID_W-1:0] id;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [DIST_W-1:0] distance;
    logic [DIR_W-1:0] nx;
    logic [DIR_W-1:0] ny;
  } hit_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [POS_W-1:0] cfg_wdata = '0;

  ray_closest_hit_2d_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Configuration as the block should hold it.
  longint org_x = 0, org_y = 0, ray_dx = 16384, ray_dy = 0;
  longint max_dist = 8388607, thr = 512;
  // Nearest-hit search state.
  longint best_d, best_ident, best_cx, best_cy, best_ox, best_oy, seen;
  bit found, query_open = 0;

  collider_t pending[$];
  hit_t hits_due[$];
  int errors = 0, mismatches = 0;
  bit quiet = 0;
  int hold_req = 0, hold_done = 0;
  bit in_took = 0;
  longint cycles = 0;

  function automatic longint sqrt_floor(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint unit_part(longint c, longint len);
    longint a, q;
    a = c < 0 ? -c : c;
    q = ((a << 28) + len / 2) / len;
    if (q > 16384) q = 16384;
    return c < 0 ? -q : q;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic track_collider(input longint px, input longint py, input longint id,
                                input bit last);
    longint proj, cx, cy, ox, oy, m, len;
    hit_t h;
    if (!query_open) begin
      best_d = max_dist; best_ident = 0; found = 0;
      best_cx = 0; best_cy = 0; best_ox = 0; best_oy = 0; seen = 0;
      query_open = 1;
    end
    if (seen < MAX_QUERY) begin
      seen++;
      proj = ((px - org_x) * ray_dx + (py - org_y) * ray_dy) >>> 14;
      if (proj > 0 && proj < best_d) begin
        cx = org_x + ((ray_dx * proj) >>> 14);
        cy = org_y + ((ray_dy * proj) >>> 14);
        ox = cx - px;
        oy = cy - py;
        if (ox * ox + oy * oy < thr * thr) begin
          best_d = proj; best_ident = id; found = 1;
          best_cx = clamp24(cx); best_cy = clamp24(cy);
          best_ox = ox; best_oy = oy;
        end
      end
    end
    if (last) begin
      h = '{default: '0};
      if (found) begin
        h.found = 1'b1; h.id = ID_W'(best_ident);
        h.px = POS_W'(best_cx); h.py = POS_W'(best_cy); h.distance = DIST_W'(best_d);
        m = best_ox * best_ox + best_oy * best_oy;
        if (m != 0) begin
          len = sqrt_floor(m << 28);
          h.nx = DIR_W'(unit_part(best_ox, len));
          h.ny = DIR_W'(unit_part(best_oy, len));
        end
      end
      hits_due = {hits_due, h};
      query_open = 0;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Input side: prediction on each accepted transfer.
  always @(posedge clk) begin
    in_took <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      track_collider($signed(in_tdata[23:0]), $signed(in_tdata[47:24]), in_tdata[57:48],
                     in_tlast);
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_took)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 0;
      end else if (pending.size() > 0) begin
        collider_t c;
        c = pending.pop_front();
        in_tdata <= {6'b0, c.id, c.py, c.px};
        in_tlast <= c.last;
        in_tvalid <= 1;
        tx_gap <= pick_gap();
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request.
  int rx_gap = 0, hold_left = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= 3000;
      out_tready <= 0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 0;
    end else begin
      rx_gap <= pick_gap();
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      hit_t e, a;
      a.found = out_tuser; a.id = out_tdata[9:0]; a.px = out_tdata[33:10];
      a.py = out_tdata[57:34]; a.distance = out_tdata[80:58];
      a.nx = out_tdata[96:81]; a.ny = out_tdata[112:97];
      if (hits_due.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result transfer: tuser=%0b tdata=%h",
                                        out_tuser, out_tdata);
      end else begin
        e = hits_due.pop_front();
        if (a != e) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected found=%0b id=%0d pt=(%0d,%0d) d=%0d n=(%0d,%0d) got found=%0b id=%0d pt=(%0d,%0d) d=%0d n=(%0d,%0d)",
                     e.found, e.id, $signed(e.px), $signed(e.py), e.distance, $signed(e.nx),
                     $signed(e.ny), a.found, a.id, $signed(a.px), $signed(a.py), a.distance,
                     $signed(a.nx), $signed(a.ny));
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input longint value);
    @(negedge clk);
    cfg_we = 1; cfg_addr = addr; cfg_wdata = POS_W'(value);
    case (addr)
      REG_ORIGIN_X: org_x = $signed(value[23:0]);
      REG_ORIGIN_Y: org_y = $signed(value[23:0]);
      REG_DIR_X:    ray_dx = $signed(value[15:0]);
      REG_DIR_Y:    ray_dy = $signed(value[15:0]);
      REG_MAX_DIST: max_dist = value[22:0];
      REG_HIT_THR:  thr = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic setup_ray(input longint ox, input longint oy, input longint dx,
                           input longint dy, input longint md, input longint th);
    write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_DIR_X, dx); write_reg(REG_DIR_Y, dy);
    write_reg(REG_MAX_DIST, md); write_reg(REG_HIT_THR, th);
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_tvalid || hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(input longint px, input longint py, input int id, input bit last);
    collider_t c;
    c.px = POS_W'(px); c.py = POS_W'(py); c.id = ID_W'(id); c.last = last;
    pending = {pending, c};
  endtask

  // A collider placed close to the current ray, so that it is often a hit.
  task automatic send_near(input bit last);
    longint t, spread;
    t = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4000000) : $urandom_range(0, 6000);
    t -= 50;
    spread = thr < 4096 ? thr + 64 : 4096;
    send(org_x + ((ray_dx * t) >>> 14) + $signed($urandom_range(0, 2 * spread)) - spread,
         org_y + ((ray_dy * t) >>> 14) + $signed($urandom_range(0, 2 * spread)) - spread,
         $urandom_range(0, 1023), last);
  endtask

  task automatic random_setup();
    longint ox, oy, dx, dy, md, th;
    int sx, sy;
    if ($urandom_range(0, 4) == 0) begin
      ox = $signed(24'($urandom)); oy = $signed(24'($urandom));
    end else begin
      ox = $signed($urandom_range(0, 200000)) - 100000;
      oy = $signed($urandom_range(0, 200000)) - 100000;
    end
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 4))
      0: begin dx = 16384 * sx; dy = 0; end
      1: begin dx = 0; dy = 16384 * sy; end
      2: begin dx = 11585 * sx; dy = 11585 * sy; end
      3: begin dx = 13107 * sx; dy = 9830 * sy; end
      default: begin
        dx = $signed($urandom_range(0, 32768)) - 16384;
        dy = $signed($urandom_range(0, 32768)) - 16384;
      end
    endcase
    case ($urandom_range(0, 9))
      0: md = 0;
      1: md = 8388607;
      2: md = $urandom_range(0, 8388607);
      default: md = $urandom_range(1, 1600000);
    endcase
    case ($urandom_range(0, 19))
      0: th = 0;
      1: th = 65535;
      2: th = $urandom_range(0, 65535);
      default: th = $urandom_range(64, 2048);
    endcase
    setup_ray(ox, oy, dx, dy, md, th);
  endtask

  task automatic random_queries(input int count);
    int n;
    bit noisy;
    repeat (count) begin
      n = $urandom_range(1, 8);
      noisy = $urandom_range(0, 4) == 0;
      for (int i = 0; i < n; i++) begin
        if (noisy && $urandom_range(0, 1))
          send($signed(24'($urandom)), $signed(24'($urandom)), $urandom_range(0, 1023),
               i == n - 1);
        else
          send_near(i == n - 1);
      end
    end
  endtask

  initial begin
    int sent_phases;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Default ray along +x, threshold 2.0.
    send(1280, 0, 1, 1);                 // exact hit, zero offset
    send(-1280, 100, 2, 0);              // behind the origin
    send(0, 0, 3, 0);                    // projection of zero
    send(2560, 512, 4, 0);               // perpendicular exactly at threshold
    send(2560, 511, 5, 0);               // just inside
    send(2560, -300, 6, 1);              // same projection: earlier one kept
    send(8388607, 8388607, 1023, 0);
    send(-8388608, -8388608, 0, 1);      // extremes, no hit
    wait_idle();
    write_reg(REG_SPARE_6, 24'hFFFFFF);
    write_reg(REG_SPARE_7, 24'h000001);
    // Non-unit direction, origin at a corner of the position range.
    setup_ray(8388607, -8388608, -16384, 16384, 8388607, 65535);
    send(8388607 - 20000, -8388608 + 20000, 7, 1);
    send(0, 0, 8, 1);
    wait_idle();
    setup_ray(-8388608, 8388607, 16384, 16384, 8388607, 65535);
    send(0, 0, 9, 0);
    send(-8388608 + 300, 8388607, 10, 1);
    wait_idle();
    // Change of max distance while a query stays open.
    setup_ray(0, 0, 0, -16384, 0, 512);
    send(0, -1000, 11, 0);
    wait_idle();
    write_reg(REG_MAX_DIST, 5000);
    send(0, -2000, 12, 1);               // still cut off by the old bound
    send(0, -2000, 13, 1);
    wait_idle();
    write_reg(REG_HIT_THR, 0);
    send(0, -2000, 14, 1);
    wait_idle();

    sent_phases = 0;
    while (sent_phases < 40) begin
      random_setup();
      quiet = sent_phases % 9 == 4;
      if (sent_phases == 7) hold_req = 1;
      if (sent_phases == 20) begin
        // Overlong query: only the first MAX_QUERY items are weighed.
        for (int i = 0; i < MAX_QUERY + 6; i++) send_near(i == MAX_QUERY + 5);
      end
      random_queries(4);
      wait_idle();
      sent_phases++;
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
